[design/mbe_pkg.sv]
// Shared constants, types and the saturation helper for the Mandelbrot
// escape-time block. No dependencies.
package mbe_pkg;

   // fixed-point format of every coordinate (signed Q4.28)
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 28;
   localparam int PIXEL_BITS = 12;
   localparam int SPAN_BITS  = 31;
   localparam int LIMIT_BITS = 16;
   localparam int COUNT_BITS = LIMIT_BITS + 1;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // restoring divider: numerator is pixel << FRAC_BITS
   localparam int QUO_BITS     = PIXEL_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

   // product and sum widths
   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int SQ_BITS   = PROD_BITS - FRAC_BITS;   // product >> FRAC_BITS
   localparam int XY_BITS   = SQ_BITS + 1;             // product >> (FRAC_BITS-1)
   localparam int WIDE_BITS = XY_BITS + 1;
   localparam int SAT_BITS  = (QUO_BITS + 1 > WIDE_BITS) ? QUO_BITS + 1 : WIDE_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SAT_BITS-1:0]   wide_type;

   localparam wide_type HALF_ONE     = SAT_BITS'(1) << (FRAC_BITS - 1);
   localparam wide_type ESCAPE_BOUND = SAT_BITS'(4) << FRAC_BITS;

   // reset values of the registers
   localparam logic [SPAN_BITS-1:0]  SPAN_RESET   = SPAN_BITS'(1) << FRAC_BITS;
   localparam logic [PIXEL_BITS-1:0] WIDTH_RESET  = PIXEL_BITS'(80);
   localparam logic [PIXEL_BITS-1:0] HEIGHT_RESET = PIXEL_BITS'(25);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(255);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_RE      = 3'd0,
      CSR_FRAME_IM      = 3'd1,
      CSR_SPAN_RE       = 3'd2,
      CSR_SPAN_IM       = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5,
      CSR_ITER_LIMIT    = 3'd6
   } csr_index_type;

   // clamp a wide signed value to the coordinate range
   function automatic coord_type sat_coord(input wide_type v);
      logic      overflow;
      coord_type result;
      overflow = (v[SAT_BITS-1:COORD_BITS-1] != {(SAT_BITS-COORD_BITS+1){v[SAT_BITS-1]}});
      if (!overflow) begin
         result = v[COORD_BITS-1:0];
      end else if (v[SAT_BITS-1]) begin
         result = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

[design/mandelbrot_escape_time.sv]
// Mandelbrot escape-time block: maps a pixel to c and counts z = z^2 + c passes.
// Depends on mbe_pkg.
//
// One request carries a pixel (pixel_x, pixel_y); one response carries its
// escape count. The pixel maps to c = span * (pixel/screen - 0.5) + frame in
// signed Q4.28; a screen size of zero counts as one. From z = 0 the block
// iterates z = z^2 + c, checking zx^2 + zy^2 >= 4 (exact wide sum) before each
// pass and stopping once the pass count exceeds iteration_limit, so a point
// that never escapes returns iteration_limit + 1. New z parts saturate to the
// 32-bit range. The block is idle again in the same cycle as the response
// becomes valid. Each axis runs through the bit-serial restoring divider and
// then the mapping steps (offset, multiply, add); every pass then goes through
// the xx, yy, xy and update states because the single 32x32 multiplier is
// reused for zx*zx, zy*zy and zx*zy in turn, and a final xx, yy, xy round
// makes the escape or limit check. The done step stalls for as long as the
// previous response still waits in the output register. The block takes a
// new request whenever it is idle, even while the last response still waits
// in the output register. Registers may be written only while idle.
module mandelbrot_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   // request stream; tdata: [11:0] pixel_x, [23:12] pixel_y
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mbe_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // response stream; tdata: [16:0] escape_count, [23:17] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbe_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // register writes
   input  logic                                csr_we,
   input  logic [mbe_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import mbe_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_DIV     = 10'b0000000010,   // one quotient bit per cycle
      ST_MAP_OFS = 10'b0000000100,   // u = sat(q - 0.5)
      ST_MAP_MUL = 10'b0000001000,   // u * span
      ST_MAP_ADD = 10'b0000010000,   // c = sat(product + frame)
      ST_IT_XX   = 10'b0000100000,   // zx * zx
      ST_IT_YY   = 10'b0001000000,   // zy * zy, latch zx^2
      ST_IT_XY   = 10'b0010000000,   // zx * zy, escape test
      ST_IT_UPD  = 10'b0100000000,   // write back new z
      ST_DONE    = 10'b1000000000    // hand result to output register
   } state_type;

   // ---------------- configuration registers ----------------
   coord_type               frame_re_ff, frame_im_ff;
   logic [SPAN_BITS-1:0]    span_re_ff, span_im_ff;
   logic [PIXEL_BITS-1:0]   width_ff, height_ff;
   logic [LIMIT_BITS-1:0]   limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_re_ff <= '0;
         frame_im_ff <= '0;
         span_re_ff  <= SPAN_RESET;
         span_im_ff  <= SPAN_RESET;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         limit_ff    <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FRAME_RE:      frame_re_ff <= coord_type'(csr_wdata[COORD_BITS-1:0]);
            CSR_FRAME_IM:      frame_im_ff <= coord_type'(csr_wdata[COORD_BITS-1:0]);
            CSR_SPAN_RE:       span_re_ff  <= csr_wdata[SPAN_BITS-1:0];
            CSR_SPAN_IM:       span_im_ff  <= csr_wdata[SPAN_BITS-1:0];
            CSR_SCREEN_WIDTH:  width_ff    <= csr_wdata[PIXEL_BITS-1:0];
            CSR_SCREEN_HEIGHT: height_ff   <= csr_wdata[PIXEL_BITS-1:0];
            CSR_ITER_LIMIT:    limit_ff    <= csr_wdata[LIMIT_BITS-1:0];
            default: ;   // unused index: ignored
         endcase
      end
   end

   // ---------------- datapath and sequencer state ----------------
   state_type                  state_ff, state_in;
   logic                       axis_ff, axis_in;       // 0: real, 1: imaginary
   logic [DIV_CNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic [QUO_BITS-1:0]        num_ff, num_in;         // numerator in, quotient out
   logic [PIXEL_BITS-1:0]      rem_ff, rem_in;
   logic [PIXEL_BITS-1:0]      den_ff, den_in;
   logic [PIXEL_BITS-1:0]      py_ff, py_in;
   coord_type                  ofs_ff, ofs_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   coord_type                  cre_ff, cre_in, cim_ff, cim_in;
   coord_type                  zx_ff, zx_in, zy_ff, zy_in;
   logic signed [SQ_BITS-1:0]  zx2_ff, zx2_in, zy2_ff, zy2_in;
   logic [COUNT_BITS-1:0]      n_ff, n_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;

   // shared multiplier operands
   coord_type mul_a, mul_b;

   // divider step
   logic [PIXEL_BITS:0]   trial;
   logic                  div_ge;
   logic [PIXEL_BITS:0]   trial_diff;

   // derived values
   logic [PIXEL_BITS-1:0]      width_den, height_den;
   logic signed [SQ_BITS-1:0]  sq_now;
   logic signed [XY_BITS-1:0]  xy_now;
   logic [SPAN_BITS-1:0]       span_sel;
   coord_type                  frame_sel;
   coord_type                  map_c;
   logic                       escaped;
   logic                       over_limit;
   logic                       out_free;
   logic                       req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-COUNT_BITS){1'b0}}, rsp_count_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign width_den  = (width_ff  == '0) ? PIXEL_BITS'(1) : width_ff;
   assign height_den = (height_ff == '0) ? PIXEL_BITS'(1) : height_ff;

   assign trial      = {rem_ff, num_ff[QUO_BITS-1]};
   assign div_ge     = (trial >= {1'b0, den_ff});
   assign trial_diff = trial - {1'b0, den_ff};

   // floor shifts of the registered product are plain part-selects
   assign sq_now = prod_ff[PROD_BITS-1:FRAC_BITS];
   assign xy_now = prod_ff[PROD_BITS-1:FRAC_BITS-1];

   assign span_sel  = axis_ff ? span_im_ff : span_re_ff;
   assign frame_sel = axis_ff ? frame_im_ff : frame_re_ff;
   assign map_c     = sat_coord(wide_type'(sq_now) + wide_type'(frame_sel));

   assign escaped    = (wide_type'(zx2_ff) + wide_type'(sq_now)) >= ESCAPE_BOUND;
   assign over_limit = n_ff > {1'b0, limit_ff};

   always_comb begin
      unique case (state_ff)
         ST_MAP_MUL: begin
            mul_a = ofs_ff;
            mul_b = coord_type'({1'b0, span_sel});
         end
         ST_IT_XX: begin
            mul_a = zx_ff;
            mul_b = zx_ff;
         end
         ST_IT_YY: begin
            mul_a = zy_ff;
            mul_b = zy_ff;
         end
         ST_IT_XY: begin
            mul_a = zx_ff;
            mul_b = zy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // 32x32 signed product; operands sign-extended to the product width
   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      div_cnt_in   = div_cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      py_in        = py_ff;
      ofs_in       = ofs_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      zx2_in       = zx2_ff;
      zy2_in       = zy2_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               py_in      = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
               num_in     = {req_tdata[PIXEL_BITS-1:0], {FRAC_BITS{1'b0}}};
               den_in     = width_den;
               rem_in     = '0;
               div_cnt_in = '0;
               axis_in    = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = div_ge ? trial_diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
            num_in     = {num_ff[QUO_BITS-2:0], div_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
            if (div_cnt_ff == DIV_CNT_BITS'(QUO_BITS - 1)) begin
               state_in = ST_MAP_OFS;
            end
         end
         ST_MAP_OFS: begin
            ofs_in   = sat_coord(wide_type'({{(SAT_BITS-QUO_BITS){1'b0}}, num_ff}) - HALF_ONE);
            state_in = ST_MAP_MUL;
         end
         ST_MAP_MUL: begin
            state_in = ST_MAP_ADD;
         end
         ST_MAP_ADD: begin
            if (!axis_ff) begin
               cre_in     = map_c;
               axis_in    = 1'b1;
               num_in     = {py_ff, {FRAC_BITS{1'b0}}};
               den_in     = height_den;
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               cim_in   = map_c;
               zx_in    = '0;
               zy_in    = '0;
               n_in     = '0;
               state_in = ST_IT_XX;
            end
         end
         ST_IT_XX: begin
            state_in = ST_IT_YY;
         end
         ST_IT_YY: begin
            zx2_in   = sq_now;
            state_in = ST_IT_XY;
         end
         ST_IT_XY: begin
            zy2_in = sq_now;
            if (escaped || over_limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_IT_UPD;
            end
         end
         ST_IT_UPD: begin
            zx_in    = sat_coord(wide_type'(zx2_ff) - wide_type'(zy2_ff) + wide_type'(cre_ff));
            zy_in    = sat_coord(wide_type'(xy_now) + wide_type'(cim_ff));
            n_in     = n_ff + COUNT_BITS'(1);
            state_in = ST_IT_XX;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = n_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath
   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      div_cnt_ff   <= div_cnt_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      py_ff        <= py_in;
      ofs_ff       <= ofs_in;
      prod_ff      <= prod_in;
      cre_ff       <= cre_in;
      cim_ff       <= cim_in;
      zx_ff        <= zx_in;
      zy_ff        <= zy_in;
      zx2_ff       <= zx2_in;
      zy2_ff       <= zy2_in;
      n_ff         <= n_in;
      rsp_count_ff <= rsp_count_in;
   end

   // ---------------- assertions ----------------
   a_accept_starts_div : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_DIV && !axis_ff && div_cnt_ff == '0))
      else $error("accepted request did not start the divider");

   a_div_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= DIV_CNT_BITS'(QUO_BITS - 1)))
      else $error("divider step count out of range");

   a_pass_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IT_XX) |-> (n_ff <= {1'b0, limit_ff} + COUNT_BITS'(1)))
      else $error("pass count beyond limit + 1");

   a_result_only_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE && rsp_count_ff == $past(n_ff)))
      else $error("response loaded outside the done step");

   a_done_holds_when_blocked : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register was full");

endmodule
